// File: src/sfrx_pkg.sv
// ----------------------------------------------------------------------------
// sfrx_pkg: shared constants and types of the serial frame receiver
// Frame layout, field widths and the parser phase encoding.
// ----------------------------------------------------------------------------
package sfrx_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int NUM_WORDS   = 6;
   localparam int FRAME_LEN   = 27;                      // header, payload, check
   localparam int PAYLOAD_LEN = FRAME_LEN - 3;
   localparam int PAYLOAD_W   = PAYLOAD_LEN * BYTE_W;
   localparam int COUNT_W     = $clog2(PAYLOAD_LEN + 1);

   localparam logic [BYTE_W-1:0] HEAD_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] HEAD_SECOND = 8'h55;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_HEAD2 = 2'd1,
      PH_DATA  = 2'd2
   } phase_type;

endpackage

// File: src/sfrx_parser.sv
// ----------------------------------------------------------------------------
// sfrx_parser: header hunt, payload collection and XOR check
// Consumes one byte per step; flags a good frame in the step of its check byte.
// ----------------------------------------------------------------------------
module sfrx_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [sfrx_pkg::BYTE_W-1:0]   rx_byte,
   output logic                          frame_good,
   output logic [sfrx_pkg::PAYLOAD_W-1:0] payload
);
   import sfrx_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]    xor_ff, xor_in;
   logic [PAYLOAD_W-1:0] shift_ff, shift_in;

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      xor_in     = xor_ff;
      shift_in   = shift_ff;
      frame_good = 1'b0;
      if (step) begin
         unique case (phase_ff)
            PH_HEAD2: begin
               if (rx_byte == HEAD_SECOND) begin
                  phase_in = PH_DATA;
                  count_in = '0;
                  xor_in   = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_DATA: begin
               if (count_ff < COUNT_W'(PAYLOAD_LEN)) begin
                  // shift in from the top: first payload byte ends up lowest
                  shift_in = {rx_byte, shift_ff[PAYLOAD_W-1:BYTE_W]};
                  xor_in   = xor_ff ^ rx_byte;
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  phase_in   = PH_HUNT;
                  count_in   = '0;
                  xor_in     = '0;
                  frame_good = (rx_byte == xor_ff);
               end
            end
            default: begin
               phase_in = (rx_byte == HEAD_FIRST) ? PH_HEAD2 : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         xor_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   assign payload = shift_ff;

endmodule

// File: src/serial_frame_receiver_xor_check.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_xor_check: framed serial byte receiver
// Finds 0xAA 0x55 headers, collects 24 payload bytes, checks their XOR and
// emits six little-endian 32-bit words per good frame.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------
//  req     | in  | req_tvalid/tready   | req_tdata[7:0]   rx_byte
//  rsp     | out | rsp_tvalid/tready   | rsp_tdata[191:0] six 32-bit words
//
//  One byte per cycle sustained while rsp is not stalled. A byte waits in
//  the input register until parsed; a good frame's words are loaded on rsp
//  as its check byte is parsed. Reset (synchronous) returns the parser to
//  header hunt and empties both registers. A stalled result holds the
//  parser; the input register takes one more byte before req_tready drops.
//
module serial_frame_receiver_xor_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [7:0] rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] pos_x_bits, [63:32] pos_y_bits, [95:64] vel_x_bits,
   // [127:96] vel_y_bits, [159:128] ang_rate_bits, [191:160] heading_bits
   output logic [sfrx_pkg::PAYLOAD_W-1:0] rsp_tdata
);
   import sfrx_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]    in_data_ff, in_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAYLOAD_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 advance;
   logic                 step;
   logic                 frame_good;
   logic [PAYLOAD_W-1:0] payload;
   logic                 req_take;

   // advance the parser only when the result register can take a result
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   sfrx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_data_ff),
      .frame_good (frame_good),
      .payload    (payload)
   );

   // input register: load on accept, drop once parsed
   always_comb begin
      in_data_in = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // result register: load on good check byte, drop when taken
   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (step && frame_good) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = payload;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: src/sfrx_checker.sv
// ----------------------------------------------------------------------------
// sfrx_checker: port-level checks of the serial frame receiver
// Reset, result spacing and stall behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module sfrx_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [sfrx_pkg::PAYLOAD_W-1:0] rsp_tdata
);

   // reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds its words
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // a frame is many bytes long: no result directly after one is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> !rsp_tvalid)
      else $error("results too close together");

   // while the result stays stalled, only one byte is buffered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && req_tvalid && req_tready)
      ##1 (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("byte taken while input register full");

endmodule

bind serial_frame_receiver_xor_check sfrx_checker u_sfrx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
